FILE: src/u7d_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-7 stream decoder: mode type, queue entry type,
// character and surrogate constants and the base64 digit decoder.
// Depends on nothing.
package u7d_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned CNT_W      = 4;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_D0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_D9    = 8'h39;

    localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;
    localparam logic [UNIT_W-1:0] SURR_HIGH = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW  = 16'hDC00;
    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h010000;

    typedef enum logic [1:0] {
        MODE_DIRECT  = 2'd0,
        MODE_BASE64  = 2'd1,
        MODE_PENDING = 2'd2
    } t_mode;

    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
    } t_entry;

    typedef struct packed {
        logic       is_b64;
        logic [5:0] val;
    } t_b64;

    function automatic t_b64 b64_decode(input logic [BYTE_W-1:0] b);
        t_b64              r;
        logic [BYTE_W-1:0] d;
        r = '0;
        d = '0;
        if (b >= CH_UA && b <= CH_UZ) begin
            d = b - CH_UA;
            r = '{is_b64: 1'b1, val: d[5:0]};
        end else if (b >= CH_LA && b <= CH_LZ) begin
            d = b - CH_LA + 8'd26;
            r = '{is_b64: 1'b1, val: d[5:0]};
        end else if (b >= CH_D0 && b <= CH_D9) begin
            d = b - CH_D0 + 8'd52;
            r = '{is_b64: 1'b1, val: d[5:0]};
        end else if (b == CH_PLUS) begin
            r = '{is_b64: 1'b1, val: 6'd62};
        end else if (b == CH_SLASH) begin
            r = '{is_b64: 1'b1, val: 6'd63};
        end
        return r;
    endfunction

endpackage

FILE: src/utf7_stream_decoder.sv
`timescale 1ns / 1ps
// UTF-7 stream decoder: one byte in per cycle, code points out one per cycle
// while i_ready is high. A byte's first result passes the entry queue, then the
// output register. Throughput: a byte every cycle while the entry queue has room;
// a byte that yields two code points holds them in the output register in turn.
// Reset (synchronous, active low) returns to direct mode, drops held bits and any
// held surrogate, and empties the queue and the output register.
module utf7_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = u7d_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [u7d_pkg::BYTE_W-1:0]  i_byte_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u7d_pkg::CP_W-1:0]    o_code_point,
    output logic                        o_last
);
    import u7d_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_entry  wr_entry;
    t_entry  rd_entry;

    u7d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_byte_req (i_byte_req),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (wr_entry)
    );

    u7d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (wr_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (rd_entry)
    );

    u7d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_entry      (rd_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_last       (o_last)
    );

endmodule

FILE: src/u7d_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the decoder mode and base64 bits, and
// pushes the one or two code points a byte yields, if any, into the queue.
// Depends on u7d_pkg.
module u7d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [u7d_pkg::BYTE_W-1:0]    i_byte_req,
    input  logic                          i_full,
    output logic                          o_push,
    output u7d_pkg::t_entry               o_entry
);
    import u7d_pkg::*;

    t_mode               r_mode, n_mode;
    logic [UNIT_W-1:0]   r_buf, n_buf;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [UNIT_W-1:0]   r_held, n_held;

    logic                accept;
    logic                push;
    t_b64                dig;
    logic                eff_b64;
    logic [21:0]         acc;
    logic [21:0]         acc_sh;
    logic [21:0]         rem;
    logic [4:0]          cnt5;
    logic [4:0]          sh5;
    logic                full_unit;
    logic [UNIT_W-1:0]   uc;
    logic [CP_W-1:0]     joined;
    logic [CP_W-1:0]     byte_cp;
    logic [CP_W-1:0]     held_cp;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && push;

    assign dig     = b64_decode(i_byte_req);
    assign eff_b64 = (r_mode == MODE_BASE64) ||
                     (r_mode == MODE_PENDING && i_byte_req != CH_MINUS);

    assign acc       = {r_buf, 6'b0} | {16'b0, dig.val};
    assign cnt5      = {1'b0, r_cnt} + 5'd6;
    assign full_unit = cnt5 >= 5'd16;
    assign sh5       = cnt5 - 5'd16;
    assign acc_sh    = acc >> sh5[2:0];
    assign uc        = acc_sh[UNIT_W-1:0];
    assign rem       = acc & ~(22'h3FFFFF << sh5[2:0]);
    assign joined    = SUPP_BASE + {1'b0, r_held[9:0], 10'b0} + {11'b0, uc[9:0]};
    assign byte_cp   = {13'b0, i_byte_req};
    assign held_cp   = {5'b0, r_held};

    always_comb begin
        n_mode = r_mode;
        if (i_cmd == CMD_CLEAR) begin
            n_mode = MODE_DIRECT;
        end else begin
            case (r_mode)
                MODE_PENDING: begin
                    if (i_byte_req == CH_MINUS) begin
                        n_mode = MODE_DIRECT;
                    end else begin
                        n_mode = dig.is_b64 ? MODE_BASE64 : MODE_DIRECT;
                    end
                end
                MODE_BASE64: begin
                    n_mode = dig.is_b64 ? MODE_BASE64 : MODE_DIRECT;
                end
                default: begin
                    n_mode = (i_byte_req == CH_PLUS) ? MODE_PENDING : MODE_DIRECT;
                end
            endcase
        end
    end

    always_comb begin
        push    = 1'b0;
        o_entry = '0;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_held  = r_held;
        if (i_cmd == CMD_CLEAR) begin
            n_buf  = '0;
            n_cnt  = '0;
            n_held = '0;
        end else if (r_mode == MODE_PENDING && i_byte_req == CH_MINUS) begin
            push        = 1'b1;
            o_entry.cp0 = {13'b0, CH_PLUS};
        end else if (eff_b64) begin
            if (dig.is_b64) begin
                n_buf = acc[UNIT_W-1:0];
                n_cnt = cnt5[CNT_W-1:0];
                if (full_unit) begin
                    n_buf = rem[UNIT_W-1:0];
                    n_cnt = sh5[CNT_W-1:0];
                    if ((uc & SURR_MASK) == SURR_HIGH) begin
                        n_held = uc;
                        if (r_held != '0) begin
                            push        = 1'b1;
                            o_entry.cp0 = held_cp;
                        end
                    end else if (r_held != '0) begin
                        push   = 1'b1;
                        n_held = '0;
                        if ((uc & SURR_MASK) == SURR_LOW) begin
                            o_entry.cp0 = joined;
                        end else begin
                            o_entry.two = 1'b1;
                            o_entry.cp0 = held_cp;
                            o_entry.cp1 = {5'b0, uc};
                        end
                    end else begin
                        push        = 1'b1;
                        o_entry.cp0 = {5'b0, uc};
                    end
                end
            end else begin
                n_buf  = '0;
                n_cnt  = '0;
                n_held = '0;
                if (r_held != '0) begin
                    push        = 1'b1;
                    o_entry.cp0 = held_cp;
                    if (i_byte_req != CH_MINUS) begin
                        o_entry.two = 1'b1;
                        o_entry.cp1 = byte_cp;
                    end
                end else if (i_byte_req != CH_MINUS) begin
                    push        = 1'b1;
                    o_entry.cp0 = byte_cp;
                end
            end
        end else if (i_byte_req != CH_PLUS) begin
            push        = 1'b1;
            o_entry.cp0 = byte_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DIRECT;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

    a_held_in_b64 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> (r_mode == MODE_BASE64))
        else $error("held surrogate outside base64 mode");

    a_buf_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf >> r_cnt) == '0)
        else $error("bit buffer holds bits above its count");

    a_pending_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PENDING) |-> (r_cnt == '0 && r_buf == '0))
        else $error("bits left over while waiting after plus");

endmodule

FILE: src/u7d_fifo.sv
`timescale 1ns / 1ps
// Short queue of decoded entries between the front end and the output stage.
// Depends on u7d_pkg.
module u7d_fifo #(
    parameter int unsigned DEPTH = u7d_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u7d_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u7d_pkg::t_entry o_entry
);
    import u7d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: src/u7d_back.sv
`timescale 1ns / 1ps
// Output stage: takes entries from the queue and presents their code points
// one item at a time from an output register, marking the final one.
// Depends on u7d_pkg.
module u7d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  u7d_pkg::t_entry             i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u7d_pkg::CP_W-1:0]    o_code_point,
    output logic                        o_last
);
    import u7d_pkg::*;

    logic             r_valid, n_valid;
    logic             r_pend, n_pend;
    logic [CP_W-1:0]  r_cp, n_cp;
    logic [CP_W-1:0]  r_cp1, n_cp1;
    logic             r_last, n_last;
    logic             load;

    assign load         = !r_valid || i_ready;
    assign o_pop        = load && !r_pend && !i_empty;
    assign o_valid      = r_valid;
    assign o_code_point = r_cp;
    assign o_last       = r_last;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_cp    = r_cp;
        n_cp1   = r_cp1;
        n_last  = r_last;
        if (load) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_pend  = 1'b0;
                n_cp    = r_cp1;
                n_last  = 1'b1;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                n_pend  = i_entry.two;
                n_cp    = i_entry.cp0;
                n_cp1   = i_entry.cp1;
                n_last  = !i_entry.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_cp1  <= n_cp1;
        r_last <= n_last;
    end

    a_pend_shown : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && !r_last))
        else $error("second code point pending without a non-final item shown");

    a_second_next : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && i_ready) |=> (r_valid && r_last && !r_pend))
        else $error("second code point not presented after the first");

endmodule
